// ----- sv/video_pixel_to_rgb888_defines.svh -----
// Assertion macros used by the pixel converter checker.
// No dependencies; taken in by `include where assertions are written.
`ifndef VIDEO_PIXEL_TO_RGB888_DEFINES_SVH
`define VIDEO_PIXEL_TO_RGB888_DEFINES_SVH

// same-cycle implication, reset masks the check
`define VPR_ASSERT_IMPL(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("vpr: same-cycle check failed");

// next-cycle implication
`define VPR_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("vpr: next-cycle check failed");

`endif

// ----- sv/vpr_pkg.sv -----
// Types and constants of the pixel to RGB888 converter.
// No dependencies; used by every other file of the block but the defines header.
package vpr_pkg;

    localparam int PIX_W     = 8;
    localparam int FMT_W     = 3;
    localparam int COEF_W    = 18;   // unsigned Q2.16, up to 2.018
    localparam int Q_SHIFT   = 16;
    localparam int SUM_W     = 28;   // signed Q.16 channel sums
    localparam int NUM_W     = 16;   // dividend c*255
    localparam int LANES     = 3;    // red, green, blue
    localparam int DIV_STEPS = 4;    // quotient bits per divider stage
    localparam int DIV_STAGES = NUM_W / DIV_STEPS;
    localparam int PIPE_DEPTH = 2 + DIV_STAGES;
    localparam int CNT_W     = $clog2(PIPE_DEPTH + 1);

    // source formats
    localparam logic [FMT_W-1:0] FMT_ARGB    = 3'd0;
    localparam logic [FMT_W-1:0] FMT_ARGB_PM = 3'd1;
    localparam logic [FMT_W-1:0] FMT_RGBA    = 3'd2;
    localparam logic [FMT_W-1:0] FMT_BGRA    = 3'd3;
    localparam logic [FMT_W-1:0] FMT_BGRA_PM = 3'd4;
    localparam logic [FMT_W-1:0] FMT_ABGR    = 3'd5;
    localparam logic [FMT_W-1:0] FMT_YUV420P = 3'd6;
    localparam logic [FMT_W-1:0] FMT_NV12    = 3'd7;

    // full-range matrix
    localparam logic [COEF_W-1:0] FR_RV = 18'd89831;
    localparam logic [COEF_W-1:0] FR_GV = 18'd45744;
    localparam logic [COEF_W-1:0] FR_GU = 18'd22127;
    localparam logic [COEF_W-1:0] FR_BU = 18'd113538;
    // limited-range matrix
    localparam logic [COEF_W-1:0] LR_Y  = 18'd76284;
    localparam logic [COEF_W-1:0] LR_RV = 18'd104595;
    localparam logic [COEF_W-1:0] LR_GV = 18'd53281;
    localparam logic [COEF_W-1:0] LR_GU = 18'd25625;
    localparam logic [COEF_W-1:0] LR_BU = 18'd132252;

    localparam logic [PIX_W-1:0] Y_FLOOR = 8'd16;

    typedef struct packed {
        logic [PIX_W-1:0] byte_0;
        logic [PIX_W-1:0] byte_1;
        logic [PIX_W-1:0] byte_2;
        logic [PIX_W-1:0] byte_3;
        logic             last_pixel;
    } pix_word_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] p_y;
        logic signed [SUM_W-1:0] p_rv;
        logic signed [SUM_W-1:0] p_gv;
        logic signed [SUM_W-1:0] p_gu;
        logic signed [SUM_W-1:0] p_bu;
        logic                    yuv;
        logic                    premult;
        logic [PIX_W-1:0]        r;
        logic [PIX_W-1:0]        g;
        logic [PIX_W-1:0]        b;
        logic [PIX_W-1:0]        a;
        logic                    last;
    } prod_word_t;

    typedef struct packed {
        logic [NUM_W-1:0] num;   // dividend bits shift out, quotient bits shift in
        logic [PIX_W-1:0] rem;
    } div_lane_t;

    typedef struct packed {
        div_lane_t [LANES-1:0] lane;
        logic [PIX_W-1:0]      divisor;
        logic                  last;
    } div_word_t;

endpackage

// ----- sv/vpr_if.sv -----
// Channel interfaces of the pixel converter: pixel in, RGB out, format config.
// Depends on vpr_pkg for field widths.
interface vpr_pixel_if;
    logic                      valid;
    logic                      ready;
    logic [vpr_pkg::PIX_W-1:0] byte_0;
    logic [vpr_pkg::PIX_W-1:0] byte_1;
    logic [vpr_pkg::PIX_W-1:0] byte_2;
    logic [vpr_pkg::PIX_W-1:0] byte_3;
    logic                      last_pixel;
    modport source (output valid, output byte_0, output byte_1, output byte_2,
                    output byte_3, output last_pixel, input ready);
    modport sink   (input valid, input byte_0, input byte_1, input byte_2,
                    input byte_3, input last_pixel, output ready);
endinterface

interface vpr_rgb_if;
    logic                      valid;
    logic                      ready;
    logic [vpr_pkg::PIX_W-1:0] red;
    logic [vpr_pkg::PIX_W-1:0] green;
    logic [vpr_pkg::PIX_W-1:0] blue;
    logic                      frame_end;
    modport source (output valid, output red, output green, output blue,
                    output frame_end, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input frame_end, output ready);
endinterface

interface vpr_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [vpr_pkg::FMT_W-1:0] pixel_format;
    modport source (output valid, output pixel_format, input ready);
    modport sink   (input valid, input pixel_format, output ready);
endinterface

// ----- sv/video_pixel_to_rgb888.sv -----
// Top level of the pixel to RGB888 converter: format register and pipeline.
// Depends on vpr_pkg, vpr_if, vpr_front, vpr_sum and vpr_div_stage.
//
//   channel  dir  payload                                    handshake
//   pixel    in   byte_0..byte_3, last_pixel                 valid/ready
//   rgb      out  red, green, blue, frame_end                valid/ready
//   cfg      in   pixel_format (3 bits)                      valid/ready, ready held high
//
// One pixel per clock sustained while rgb is ready; stages are products, sums/clamp and
// four divider stages of 4 quotient bits each, the last one being the output register.
// Reset clears every stage valid bit and sets the format to ARGB.
// Each stage takes a word when empty or when its successor moves, so bubbles close up
// and a stall on rgb backs up stage by stage without loss.
module video_pixel_to_rgb888
(
    input  logic      clk,
    input  logic      rst_n,
    vpr_cfg_if.sink   cfg,
    vpr_pixel_if.sink pixel,
    vpr_rgb_if.source rgb
);

    logic [vpr_pkg::FMT_W-1:0] fmt_reg;
    logic [vpr_pkg::FMT_W-1:0] fmt_next;
    vpr_pkg::pix_word_t        pix_word;
    vpr_pkg::prod_word_t       prod_word;
    logic                      prod_valid;
    logic                      prod_ready;
    vpr_pkg::div_word_t        div_word  [0:vpr_pkg::DIV_STAGES];
    logic                      div_valid [0:vpr_pkg::DIV_STAGES];
    logic                      div_ready [0:vpr_pkg::DIV_STAGES];

    assign cfg.ready = 1'b1;
    assign fmt_next  = cfg.valid ? cfg.pixel_format : fmt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg <= vpr_pkg::FMT_ARGB;
        end
        else
        begin
            fmt_reg <= fmt_next;
        end
    end

    always_comb
    begin
        pix_word.byte_0     = pixel.byte_0;
        pix_word.byte_1     = pixel.byte_1;
        pix_word.byte_2     = pixel.byte_2;
        pix_word.byte_3     = pixel.byte_3;
        pix_word.last_pixel = pixel.last_pixel;
    end

    vpr_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .fmt      (fmt_reg),
        .up_valid (pixel.valid),
        .up_ready (pixel.ready),
        .up_word  (pix_word),
        .dn_valid (prod_valid),
        .dn_ready (prod_ready),
        .dn_word  (prod_word)
    );

    vpr_sum u_sum
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (prod_valid),
        .up_ready (prod_ready),
        .up_word  (prod_word),
        .dn_valid (div_valid[0]),
        .dn_ready (div_ready[0]),
        .dn_word  (div_word[0])
    );

    for (genvar k = 0; k < vpr_pkg::DIV_STAGES; k++)
    begin : g_div
        vpr_div_stage u_div
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (div_valid[k]),
            .up_ready (div_ready[k]),
            .up_word  (div_word[k]),
            .dn_valid (div_valid[k+1]),
            .dn_ready (div_ready[k+1]),
            .dn_word  (div_word[k+1])
        );
    end

    // quotient low byte is the channel value
    assign div_ready[vpr_pkg::DIV_STAGES] = rgb.ready;
    assign rgb.valid     = div_valid[vpr_pkg::DIV_STAGES];
    assign rgb.red       = div_word[vpr_pkg::DIV_STAGES].lane[0].num[vpr_pkg::PIX_W-1:0];
    assign rgb.green     = div_word[vpr_pkg::DIV_STAGES].lane[1].num[vpr_pkg::PIX_W-1:0];
    assign rgb.blue      = div_word[vpr_pkg::DIV_STAGES].lane[2].num[vpr_pkg::PIX_W-1:0];
    assign rgb.frame_end = div_word[vpr_pkg::DIV_STAGES].last;

endmodule

// ----- sv/vpr_front.sv -----
// First stage: format decode, byte steering and the YUV matrix products.
// Depends on vpr_pkg.
module vpr_front
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [vpr_pkg::FMT_W-1:0] fmt,
    input  logic                      up_valid,
    output logic                      up_ready,
    input  vpr_pkg::pix_word_t        up_word,
    output logic                      dn_valid,
    input  logic                      dn_ready,
    output vpr_pkg::prod_word_t       dn_word
);

    logic                          valid_reg;
    logic                          valid_next;
    vpr_pkg::prod_word_t           word_reg;
    vpr_pkg::prod_word_t           word_next;
    logic                          load;
    logic                          limited;
    logic [vpr_pkg::PIX_W-1:0]     y_lim;
    logic signed [vpr_pkg::PIX_W-1:0] u_s;
    logic signed [vpr_pkg::PIX_W-1:0] v_s;
    logic [vpr_pkg::COEF_W-1:0]    c_rv;
    logic [vpr_pkg::COEF_W-1:0]    c_gv;
    logic [vpr_pkg::COEF_W-1:0]    c_gu;
    logic [vpr_pkg::COEF_W-1:0]    c_bu;

    assign up_ready = !valid_reg || dn_ready;
    assign load     = up_valid && up_ready;
    assign dn_valid = valid_reg;
    assign dn_word  = word_reg;

    always_comb
    begin
        limited = (fmt == vpr_pkg::FMT_NV12);
        y_lim   = (up_word.byte_0 < vpr_pkg::Y_FLOOR) ? '0
                                                      : up_word.byte_0 - vpr_pkg::Y_FLOOR;
        // byte - 128 as an 8-bit two's complement value
        u_s = $signed(up_word.byte_1 ^ 8'h80);
        v_s = $signed(up_word.byte_2 ^ 8'h80);
        c_rv = limited ? vpr_pkg::LR_RV : vpr_pkg::FR_RV;
        c_gv = limited ? vpr_pkg::LR_GV : vpr_pkg::FR_GV;
        c_gu = limited ? vpr_pkg::LR_GU : vpr_pkg::FR_GU;
        c_bu = limited ? vpr_pkg::LR_BU : vpr_pkg::FR_BU;

        word_next = '0;
        if (limited)
        begin
            word_next.p_y = vpr_pkg::SUM_W'($signed({1'b0, vpr_pkg::LR_Y}))
                          * vpr_pkg::SUM_W'($signed({1'b0, y_lim}));
        end
        else
        begin
            word_next.p_y = $signed(vpr_pkg::SUM_W'({up_word.byte_0, 16'h0000}));
        end
        word_next.p_rv = vpr_pkg::SUM_W'($signed({1'b0, c_rv})) * vpr_pkg::SUM_W'(v_s);
        word_next.p_gv = vpr_pkg::SUM_W'($signed({1'b0, c_gv})) * vpr_pkg::SUM_W'(v_s);
        word_next.p_gu = vpr_pkg::SUM_W'($signed({1'b0, c_gu})) * vpr_pkg::SUM_W'(u_s);
        word_next.p_bu = vpr_pkg::SUM_W'($signed({1'b0, c_bu})) * vpr_pkg::SUM_W'(u_s);
        word_next.yuv     = (fmt == vpr_pkg::FMT_YUV420P) || limited;
        word_next.premult = (fmt == vpr_pkg::FMT_ARGB_PM) || (fmt == vpr_pkg::FMT_BGRA_PM);
        word_next.last    = up_word.last_pixel;

        case (fmt)
            vpr_pkg::FMT_ARGB, vpr_pkg::FMT_ARGB_PM:
            begin
                word_next.a = up_word.byte_0;
                word_next.r = up_word.byte_1;
                word_next.g = up_word.byte_2;
                word_next.b = up_word.byte_3;
            end
            vpr_pkg::FMT_RGBA:
            begin
                word_next.r = up_word.byte_0;
                word_next.g = up_word.byte_1;
                word_next.b = up_word.byte_2;
                word_next.a = up_word.byte_3;
            end
            vpr_pkg::FMT_BGRA, vpr_pkg::FMT_BGRA_PM:
            begin
                word_next.b = up_word.byte_0;
                word_next.g = up_word.byte_1;
                word_next.r = up_word.byte_2;
                word_next.a = up_word.byte_3;
            end
            vpr_pkg::FMT_ABGR:
            begin
                word_next.a = up_word.byte_0;
                word_next.b = up_word.byte_1;
                word_next.g = up_word.byte_2;
                word_next.r = up_word.byte_3;
            end
            default:
            begin
                word_next.a = '0;
            end
        endcase
    end

    assign valid_next = up_ready ? up_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= word_next;
        end
    end

endmodule

// ----- sv/vpr_sum.sv -----
// Second stage: channel sums with clamp, packed/YUV select, divider setup.
// Depends on vpr_pkg.
module vpr_sum
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                up_valid,
    output logic                up_ready,
    input  vpr_pkg::prod_word_t up_word,
    output logic                dn_valid,
    input  logic                dn_ready,
    output vpr_pkg::div_word_t  dn_word
);

    logic                                valid_reg;
    logic                                valid_next;
    vpr_pkg::div_word_t                  word_reg;
    vpr_pkg::div_word_t                  word_next;
    logic                                load;
    logic signed [vpr_pkg::SUM_W-1:0]    r_sum;
    logic signed [vpr_pkg::SUM_W-1:0]    g_sum;
    logic signed [vpr_pkg::SUM_W-1:0]    b_sum;
    logic [vpr_pkg::LANES-1:0][vpr_pkg::PIX_W-1:0] color;

    // truncate Q.16 toward zero, clamp to 0..255
    function automatic logic [vpr_pkg::PIX_W-1:0] clamp_q16
    (
        input logic signed [vpr_pkg::SUM_W-1:0] s
    );
        logic [vpr_pkg::PIX_W-1:0] res;
        if (s[vpr_pkg::SUM_W-1])
        begin
            res = '0;
        end
        else if (s[vpr_pkg::SUM_W-2:vpr_pkg::Q_SHIFT+vpr_pkg::PIX_W] != '0)
        begin
            res = '1;
        end
        else
        begin
            res = s[vpr_pkg::Q_SHIFT+vpr_pkg::PIX_W-1:vpr_pkg::Q_SHIFT];
        end
        return res;
    endfunction

    assign up_ready = !valid_reg || dn_ready;
    assign load     = up_valid && up_ready;
    assign dn_valid = valid_reg;
    assign dn_word  = word_reg;

    always_comb
    begin
        r_sum = up_word.p_y + up_word.p_rv;
        g_sum = up_word.p_y - up_word.p_gv - up_word.p_gu;
        b_sum = up_word.p_y + up_word.p_bu;
        if (up_word.yuv)
        begin
            color[0] = clamp_q16(r_sum);
            color[1] = clamp_q16(g_sum);
            color[2] = clamp_q16(b_sum);
        end
        else
        begin
            color[0] = up_word.r;
            color[1] = up_word.g;
            color[2] = up_word.b;
        end

        word_next      = '0;
        word_next.last = up_word.last;
        // plain pass is c / 1; zero alpha is 0 / 1
        if (up_word.premult && (up_word.a != '0))
        begin
            word_next.divisor = up_word.a;
        end
        else
        begin
            word_next.divisor = vpr_pkg::PIX_W'(1);
        end
        for (int i = 0; i < vpr_pkg::LANES; i++)
        begin
            word_next.lane[i].rem = '0;
            if (!up_word.premult)
            begin
                word_next.lane[i].num = vpr_pkg::NUM_W'(color[i]);
            end
            else if (up_word.a == '0)
            begin
                word_next.lane[i].num = '0;
            end
            else
            begin
                word_next.lane[i].num = {color[i], 8'h00} - vpr_pkg::NUM_W'(color[i]);
            end
        end
    end

    assign valid_next = up_ready ? up_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= word_next;
        end
    end

endmodule

// ----- sv/vpr_div_stage.sv -----
// One divider stage: DIV_STEPS restoring-division steps on all three lanes.
// Depends on vpr_pkg.
module vpr_div_stage
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               up_valid,
    output logic               up_ready,
    input  vpr_pkg::div_word_t up_word,
    output logic               dn_valid,
    input  logic               dn_ready,
    output vpr_pkg::div_word_t dn_word
);

    logic               valid_reg;
    logic               valid_next;
    vpr_pkg::div_word_t word_reg;
    vpr_pkg::div_word_t word_next;
    logic               load;
    logic [vpr_pkg::NUM_W-1:0] num;
    logic [vpr_pkg::PIX_W:0]   trial;

    assign up_ready = !valid_reg || dn_ready;
    assign load     = up_valid && up_ready;
    assign dn_valid = valid_reg;
    assign dn_word  = word_reg;

    always_comb
    begin
        word_next = up_word;
        num       = '0;
        trial     = '0;
        for (int i = 0; i < vpr_pkg::LANES; i++)
        begin
            num   = up_word.lane[i].num;
            trial = {1'b0, up_word.lane[i].rem};
            for (int s = 0; s < vpr_pkg::DIV_STEPS; s++)
            begin
                trial = {trial[vpr_pkg::PIX_W-1:0], num[vpr_pkg::NUM_W-1]};
                num   = {num[vpr_pkg::NUM_W-2:0], 1'b0};
                if (trial >= {1'b0, up_word.divisor})
                begin
                    trial  = trial - {1'b0, up_word.divisor};
                    num[0] = 1'b1;
                end
            end
            word_next.lane[i].num = num;
            word_next.lane[i].rem = trial[vpr_pkg::PIX_W-1:0];
        end
    end

    assign valid_next = up_ready ? up_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= word_next;
        end
    end

endmodule

// ----- sv/vpr_checker.sv -----
// Port-level checks of the pixel converter, bound to the top level.
// Depends on vpr_pkg and video_pixel_to_rgb888_defines.svh.
`include "video_pixel_to_rgb888_defines.svh"

module vpr_checker
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      cfg_ready,
    input logic                      pixel_valid,
    input logic                      pixel_ready,
    input logic                      rgb_valid,
    input logic                      rgb_ready,
    input logic [vpr_pkg::PIX_W-1:0] rgb_red,
    input logic [vpr_pkg::PIX_W-1:0] rgb_green,
    input logic [vpr_pkg::PIX_W-1:0] rgb_blue,
    input logic                      rgb_frame_end
);

    localparam logic [vpr_pkg::CNT_W-1:0] DEPTH = vpr_pkg::CNT_W'(vpr_pkg::PIPE_DEPTH);

    logic [vpr_pkg::CNT_W-1:0] cnt_reg;
    logic [vpr_pkg::CNT_W-1:0] cnt_next;
    logic                      in_fire;
    logic                      out_fire;
    logic [3*vpr_pkg::PIX_W:0] out_word;

    // words inside the block
    assign in_fire  = pixel_valid && pixel_ready;
    assign out_fire = rgb_valid && rgb_ready;
    assign cnt_next = cnt_reg + vpr_pkg::CNT_W'(in_fire) - vpr_pkg::CNT_W'(out_fire);
    assign out_word = {rgb_red, rgb_green, rgb_blue, rgb_frame_end};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    `VPR_ASSERT_IMPL(a_cfg_ready, clk, rst_n, 1'b1, cfg_ready)
    `VPR_ASSERT_NEXT(a_out_hold, clk, rst_n, rgb_valid && !rgb_ready, rgb_valid && $stable(out_word))
    `VPR_ASSERT_IMPL(a_out_has_word, clk, rst_n, rgb_valid, cnt_reg != '0)
    `VPR_ASSERT_IMPL(a_ready_rule, clk, rst_n, 1'b1, pixel_ready == ((cnt_reg != DEPTH) || rgb_ready))

endmodule

bind video_pixel_to_rgb888 vpr_checker u_vpr_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_ready     (cfg.ready),
    .pixel_valid   (pixel.valid),
    .pixel_ready   (pixel.ready),
    .rgb_valid     (rgb.valid),
    .rgb_ready     (rgb.ready),
    .rgb_red       (rgb.red),
    .rgb_green     (rgb.green),
    .rgb_blue      (rgb.blue),
    .rgb_frame_end (rgb.frame_end)
);
